// File: design/rici_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rici_pkg: shared constants, types and CRC function for the record checker
// Holds the record layout, the CRC-32 constants and the result beat type.
// ----------------------------------------------------------------------------
package rici_pkg;

  // Record layout.
  localparam int unsigned PosW       = 6;
  localparam logic [7:0]  MagicFirst  = 8'hB7;
  localparam logic [7:0]  MagicSecond = 8'h72;
  localparam logic [PosW-1:0] PosRecord  = 6'd36;
  localparam logic [PosW-1:0] PosLast    = 6'd35;
  localparam logic [PosW-1:0] PosCovered = 6'd32;
  localparam logic [PosW-1:0] PosModel   = 6'd2;
  localparam logic [PosW-1:0] PosVersion = 6'd3;
  localparam logic [PosW-1:0] PosPadLo   = 6'd4;
  localparam logic [PosW-1:0] PosPadHi   = 6'd7;
  localparam logic [PosW-1:0] PosWordLo  = 6'd12;
  localparam logic [PosW-1:0] PosWordHi  = 6'd31;
  localparam logic [PosW-1:0] PosCheckLo = 6'd32;
  localparam logic [PosW-1:0] PosCheckHi = 6'd34;
  localparam int unsigned WordBytes  = 20;
  localparam int unsigned WordIdxW   = 5;

  // Reflected CRC-32 constants.
  localparam logic [31:0] CrcPoly = 32'hEDB88320;
  localparam logic [31:0] CrcOnes = 32'hFFFFFFFF;

  // One result beat.
  typedef struct packed {
    logic        record_ok;
    logic [7:0]  adapter_model;
    logic [7:0]  adapter_version;
    logic [7:0]  padmap_id_0;
    logic [7:0]  padmap_id_1;
    logic [7:0]  padmap_id_2;
    logic [7:0]  padmap_id_3;
    logic [31:0] lifespan_word;
    logic [31:0] manufacture_date;
    logic [31:0] insertion_total;
    logic [31:0] test_total;
    logic [31:0] end_of_life_word;
  } rici_result_t;

  // Eight bit-steps of the reflected CRC, one input byte.
  function automatic logic [31:0] crc_byte_update(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h000000, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: design/rici_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rici_in_if: record byte channel
// Carries one record byte and its start flag per beat.
// ----------------------------------------------------------------------------
interface rici_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rec_byte;
  logic       rec_first;

  modport source (output valid, output rec_byte, output rec_first, input ready);
  modport sink   (input valid, input rec_byte, input rec_first, output ready);
endinterface
`default_nettype wire

// File: design/rici_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rici_out_if: decoded record channel
// Carries the ok flag and the decoded fields of one record per beat.
// ----------------------------------------------------------------------------
interface rici_out_if;
  logic        valid;
  logic        ready;
  logic        record_ok;
  logic [7:0]  adapter_model;
  logic [7:0]  adapter_version;
  logic [7:0]  padmap_id_0;
  logic [7:0]  padmap_id_1;
  logic [7:0]  padmap_id_2;
  logic [7:0]  padmap_id_3;
  logic [31:0] lifespan_word;
  logic [31:0] manufacture_date;
  logic [31:0] insertion_total;
  logic [31:0] test_total;
  logic [31:0] end_of_life_word;

  modport source (
    output valid, output record_ok, output adapter_model, output adapter_version,
    output padmap_id_0, output padmap_id_1, output padmap_id_2, output padmap_id_3,
    output lifespan_word, output manufacture_date, output insertion_total,
    output test_total, output end_of_life_word, input ready
  );
  modport sink (
    input valid, input record_ok, input adapter_model, input adapter_version,
    input padmap_id_0, input padmap_id_1, input padmap_id_2, input padmap_id_3,
    input lifespan_word, input manufacture_date, input insertion_total,
    input test_total, input end_of_life_word, output ready
  );
endinterface
`default_nettype wire

// File: design/rici_frame.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rici_frame: record framing, CRC and field capture
// Tracks the byte position, runs the CRC, checks the magic bytes, captures
// fields and builds the result on the last byte of a record.
// ----------------------------------------------------------------------------
module rici_frame (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  beat_i,
  input  wire logic [7:0]            byte_i,
  input  wire logic                  first_i,
  output logic                       res_valid_o,
  output rici_pkg::rici_result_t     res_o
);
  import rici_pkg::*;

  logic [PosW-1:0] pos_q, pos_d, pos_eff;
  logic [31:0]     crc_q, crc_d, crc_base;
  logic            magic_q, magic_d, magic_base;
  logic [7:0]      model_q, model_d;
  logic [7:0]      version_q, version_d;
  logic [3:0][7:0] pad_q, pad_d;
  logic [WordBytes-1:0][7:0] word_q, word_d;
  logic [2:0][7:0] check_q, check_d;
  logic [WordIdxW-1:0] word_idx;
  logic [PosW-1:0] word_off;
  logic            ok;

  // A start flag or a wrapped counter makes this byte position zero.
  assign pos_eff  = (first_i || (pos_q >= PosRecord)) ? '0 : pos_q;
  assign word_off = pos_eff - PosWordLo;
  assign word_idx = word_off[WordIdxW-1:0];
  assign crc_base   = (pos_eff == '0) ? CrcOnes : crc_q;
  assign magic_base = (pos_eff == '0) ? 1'b1 : magic_q;

  // Next-state logic for one accepted byte.
  always_comb begin
    pos_d     = pos_q;
    crc_d     = crc_q;
    magic_d   = magic_q;
    model_d   = model_q;
    version_d = version_q;
    pad_d     = pad_q;
    word_d    = word_q;
    check_d   = check_q;
    if (beat_i) begin
      pos_d   = (pos_eff == PosLast) ? '0 : pos_eff + 1'b1;
      crc_d   = (pos_eff < PosCovered) ? crc_byte_update(crc_base, byte_i) : crc_base;
      magic_d = magic_base;
      if ((pos_eff == '0) && (byte_i != MagicFirst)) begin
        magic_d = 1'b0;
      end
      if ((pos_eff == 6'd1) && (byte_i != MagicSecond)) begin
        magic_d = 1'b0;
      end
      if (pos_eff == PosModel) begin
        model_d = byte_i;
      end
      if (pos_eff == PosVersion) begin
        version_d = byte_i;
      end
      if ((pos_eff >= PosPadLo) && (pos_eff <= PosPadHi)) begin
        pad_d[pos_eff[1:0]] = byte_i;
      end
      if ((pos_eff >= PosWordLo) && (pos_eff <= PosWordHi)) begin
        word_d[word_idx] = byte_i;
      end
      if ((pos_eff >= PosCheckLo) && (pos_eff <= PosCheckHi)) begin
        check_d[pos_eff[1:0]] = byte_i;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      crc_q   <= CrcOnes;
      magic_q <= 1'b1;
    end else begin
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      magic_q <= magic_d;
    end
  end

  // Captured fields; the result gates them, so they need no reset.
  always_ff @(posedge clk_i) begin
    model_q   <= model_d;
    version_q <= version_d;
    pad_q     <= pad_d;
    word_q    <= word_d;
    check_q   <= check_d;
  end

  // The last byte completes the stored check word and closes the record.
  assign ok = magic_q && ((crc_q ^ CrcOnes) == {byte_i, check_q[2], check_q[1], check_q[0]});
  assign res_valid_o = beat_i && (pos_eff == PosLast);

  always_comb begin
    res_o = '0;
    if (ok) begin
      res_o.record_ok        = 1'b1;
      res_o.adapter_model    = model_q;
      res_o.adapter_version  = version_q;
      res_o.padmap_id_0      = pad_q[0];
      res_o.padmap_id_1      = pad_q[1];
      res_o.padmap_id_2      = pad_q[2];
      res_o.padmap_id_3      = pad_q[3];
      res_o.lifespan_word    = {word_q[3],  word_q[2],  word_q[1],  word_q[0]};
      res_o.manufacture_date = {word_q[7],  word_q[6],  word_q[5],  word_q[4]};
      res_o.insertion_total  = {word_q[11], word_q[10], word_q[9],  word_q[8]};
      res_o.test_total       = {word_q[15], word_q[14], word_q[13], word_q[12]};
      res_o.end_of_life_word = {word_q[19], word_q[18], word_q[17], word_q[16]};
    end
  end

  // The position counter never leaves the record.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < PosRecord) else $error("byte position out of range");

  // A result closes the record and the next byte starts a new one.
  a_res_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> (pos_q == '0)) else $error("position not cleared after result");

  // A start byte always advances the position to one.
  a_first_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat_i && first_i) |=> (pos_q == 6'd1)) else $error("start byte misframed");

endmodule
`default_nettype wire

// File: design/rici_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rici_out_reg: result register
// Holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module rici_out_reg (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   load_i,
  input  wire rici_pkg::rici_result_t res_i,
  output logic                        ready_o,
  rici_out_if.source                  out_chan
);
  import rici_pkg::*;

  logic         valid_q, valid_d;
  rici_result_t data_q;

  // Room exists when empty or when the held beat leaves this cycle.
  assign ready_o = !valid_q || out_chan.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_chan.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign out_chan.valid            = valid_q;
  assign out_chan.record_ok        = data_q.record_ok;
  assign out_chan.adapter_model    = data_q.adapter_model;
  assign out_chan.adapter_version  = data_q.adapter_version;
  assign out_chan.padmap_id_0      = data_q.padmap_id_0;
  assign out_chan.padmap_id_1      = data_q.padmap_id_1;
  assign out_chan.padmap_id_2      = data_q.padmap_id_2;
  assign out_chan.padmap_id_3      = data_q.padmap_id_3;
  assign out_chan.lifespan_word    = data_q.lifespan_word;
  assign out_chan.manufacture_date = data_q.manufacture_date;
  assign out_chan.insertion_total  = data_q.insertion_total;
  assign out_chan.test_total       = data_q.test_total;
  assign out_chan.end_of_life_word = data_q.end_of_life_word;

  // A new result is loaded only when there is room for it.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> ready_o) else $error("result loaded over a held beat");

  // A failed record carries all-zero fields.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !data_q.record_ok) |->
      ((data_q.adapter_model == 8'h00) && (data_q.lifespan_word == 32'h0) &&
       (data_q.end_of_life_word == 32'h0))) else $error("failed record not zeroed");

endmodule
`default_nettype wire

// File: design/record_image_checker_crc32_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// record_image_checker_crc32_core: streaming checker for a 36-byte record
// Parses a stored record one byte per beat and reports its decoded fields.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one record byte per beat; rec_first marks byte 0 and
//   drops any partial record. After 36 bytes the position wraps, so the
//   next byte starts a new record even without rec_first.
//   out_chan carries one beat per complete record: record_ok is 1 when the
//   magic bytes and the CRC-32 over bytes 0 to 31 both match the record;
//   otherwise all fields are zero.
//   Throughput is one byte per cycle unless a held result is stalled; the
//   CRC update for one byte is an eight-step unrolled network on the CRC register.
//   The result beat shows on out_chan in the cycle after the 36th byte
//   is accepted.
//   Reset clears the position, CRC and result valid; no clearing pass.
//   When the receiver stalls, the result stays held and in_chan.ready
//   drops until it is taken, so no byte is accepted while the held beat
//   waits; the cycle it leaves, a new byte can be accepted.
// ----------------------------------------------------------------------------
module record_image_checker_crc32_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rici_in_if.sink   in_chan,
  rici_out_if.source out_chan
);
  import rici_pkg::*;

  logic         beat;
  logic         room;
  logic         res_valid;
  rici_result_t res;

  assign in_chan.ready = room;
  assign beat = in_chan.valid && room;

  rici_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (beat),
    .byte_i      (in_chan.rec_byte),
    .first_i     (in_chan.rec_first),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  rici_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (res_valid),
    .res_i    (res),
    .ready_o  (room),
    .out_chan (out_chan)
  );

  // A stalled result holds off new bytes.
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_chan.valid && !out_chan.ready) |-> !in_chan.ready)
    else $error("byte accepted while result stalled");

  // A record-closing byte shows a result in the next cycle.
  a_res_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |=> out_chan.valid) else $error("result beat missing");

endmodule
`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for the streaming record checker
// Feeds 36-byte record images one byte per beat through the input channel.
// A short table of layout cases comes first, then random good, corrupted,
// truncated and noisy streams. Every result beat is compared with a local
// model of the parser, under random idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import rici_pkg::rici_result_t;

  // Record layout and CRC constants, kept local to the bench.
  localparam logic [7:0]  RecMagic0   = 8'hB7;
  localparam logic [7:0]  RecMagic1   = 8'h72;
  localparam int          RecordLen   = 36;
  localparam int          CoveredLen  = 32;
  localparam logic [31:0] CrcReflPoly = 32'hEDB88320;
  localparam logic [31:0] CrcAllOnes  = 32'hFFFFFFFF;

  // Run sizing.
  localparam int RandomBytes = 1580;
  localparam int CycleLimit  = 200000;
  localparam int TailCycles  = 8;

  typedef logic [RecordLen-1:0][7:0] image_t;

  // Kinds of record streams played by the bench.
  typedef enum logic [2:0] {
    RowGood,
    RowBadFirst,
    RowBadSecond,
    RowBadCheck,
    RowRestart,
    RowChained,
    RowNoise
  } row_kind_e;

  typedef struct {
    row_kind_e    kind;
    logic [7:0]   fill;
    bit           use_fill;
    bit           typed;
    rici_result_t want;
  } row_t;

  logic clk_i;
  logic rst_ni;

  rici_in_if  in_if ();
  rici_out_if out_if ();

  record_image_checker_crc32_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // Parser model state.
  int          cur_pos    = 0;
  logic [31:0] crc_acc    = CrcAllOnes;
  bit          magic_good = 1'b1;
  logic [7:0]  model_q    = '0;
  logic [7:0]  version_q  = '0;
  logic [7:0]  pad_q [4]  = '{default: '0};
  logic [31:0] word_q [5] = '{default: '0};
  logic [31:0] check_q    = '0;

  // Bench bookkeeping.
  rici_result_t decoded_q [$];
  rici_result_t last_beat;
  int           mismatches  = 0;
  int           results_got = 0;
  int           ok_got      = 0;
  int           bytes_sent  = 0;
  int           cycles      = 0;
  bit           idle_on     = 1'b0;
  bit           need_first  = 1'b1;
  int           stall_left  = 0;
  row_t         dir_rows [7];

  // Clock.
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // One byte through the reflected CRC, bit by bit.
  function automatic logic [31:0] crc_next(logic [31:0] c, logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) c = c ^ CrcReflPoly;
    end
    return c;
  endfunction

  // Writes the little-endian CRC of bytes 0 to 31 into bytes 32 to 35.
  function automatic image_t seal_image(image_t img);
    logic [31:0] c;
    c = CrcAllOnes;
    for (int i = 0; i < CoveredLen; i++) c = crc_next(c, img[i]);
    c = c ^ CrcAllOnes;
    for (int k = 0; k < 4; k++) img[CoveredLen + k] = c[8*k +: 8];
    return img;
  endfunction

  // A well-formed image: magic bytes, given or random body, valid CRC.
  function automatic image_t build_image(bit use_fill, logic [7:0] fill);
    image_t img;
    img    = '0;
    img[0] = RecMagic0;
    img[1] = RecMagic1;
    for (int i = 2; i < CoveredLen; i++) begin
      img[i] = use_fill ? fill : 8'($urandom_range(0, 255));
    end
    return seal_image(img);
  endfunction

  // Parser model: takes one byte, returns 1 when a record result is due.
  function automatic bit absorb_byte(input logic [7:0] b, input logic first,
                                     output rici_result_t res);
    int p;
    int sh;
    res = '0;
    if (first) cur_pos = 0;
    p = (cur_pos >= RecordLen) ? 0 : cur_pos;
    if (p == 0) begin
      crc_acc    = CrcAllOnes;
      magic_good = 1'b1;
    end
    if (p < CoveredLen) crc_acc = crc_next(crc_acc, b);

    if (p == 0 && b != RecMagic0) begin
      magic_good = 1'b0;
    end else if (p == 1 && b != RecMagic1) begin
      magic_good = 1'b0;
    end else if (p == 2) begin
      model_q = b;
    end else if (p == 3) begin
      version_q = b;
    end else if (p >= 4 && p <= 7) begin
      pad_q[p - 4] = b;
    end else if (p >= 12 && p <= 31) begin
      sh = ((p - 12) % 4) * 8;
      word_q[(p - 12) / 4][sh +: 8] = b;
    end else if (p >= 32 && p <= 35) begin
      sh = (p - 32) * 8;
      check_q[sh +: 8] = b;
    end

    if (p + 1 < RecordLen) begin
      cur_pos = p + 1;
      return 1'b0;
    end
    cur_pos = 0;
    // A failed record reports all fields as zero.
    if (magic_good && ((crc_acc ^ CrcAllOnes) == check_q)) begin
      res.record_ok        = 1'b1;
      res.adapter_model    = model_q;
      res.adapter_version  = version_q;
      res.padmap_id_0      = pad_q[0];
      res.padmap_id_1      = pad_q[1];
      res.padmap_id_2      = pad_q[2];
      res.padmap_id_3      = pad_q[3];
      res.lifespan_word    = word_q[0];
      res.manufacture_date = word_q[1];
      res.insertion_total  = word_q[2];
      res.test_total       = word_q[3];
      res.end_of_life_word = word_q[4];
    end
    return 1'b1;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_record(rici_result_t want, rici_result_t got);
    check_field("record_ok",       32'(want.record_ok),       32'(got.record_ok));
    check_field("adapter_model",   32'(want.adapter_model),   32'(got.adapter_model));
    check_field("adapter_version", 32'(want.adapter_version), 32'(got.adapter_version));
    check_field("padmap_id_0",     32'(want.padmap_id_0),     32'(got.padmap_id_0));
    check_field("padmap_id_1",     32'(want.padmap_id_1),     32'(got.padmap_id_1));
    check_field("padmap_id_2",     32'(want.padmap_id_2),     32'(got.padmap_id_2));
    check_field("padmap_id_3",     32'(want.padmap_id_3),     32'(got.padmap_id_3));
    check_field("lifespan_word",    want.lifespan_word,    got.lifespan_word);
    check_field("manufacture_date", want.manufacture_date, got.manufacture_date);
    check_field("insertion_total",  want.insertion_total,  got.insertion_total);
    check_field("test_total",       want.test_total,       got.test_total);
    check_field("end_of_life_word", want.end_of_life_word, got.end_of_life_word);
  endfunction

  // Monitor: model every accepted byte, check every accepted result beat.
  always @(posedge clk_i) begin
    rici_result_t want;
    rici_result_t got;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        if (absorb_byte(in_if.rec_byte, in_if.rec_first, want)) decoded_q.push_back(want);
      end
      if (out_if.valid && out_if.ready) begin
        got = {out_if.record_ok, out_if.adapter_model, out_if.adapter_version,
               out_if.padmap_id_0, out_if.padmap_id_1, out_if.padmap_id_2,
               out_if.padmap_id_3, out_if.lifespan_word, out_if.manufacture_date,
               out_if.insertion_total, out_if.test_total, out_if.end_of_life_word};
        last_beat = got;
        results_got++;
        if (got.record_ok) ok_got++;
        if (decoded_q.size() == 0) begin
          $error("result beat with no record pending");
          mismatches++;
        end else begin
          check_record(decoded_q.pop_front(), got);
        end
      end
    end
  end

  // Receiver: ready drops in random stall bursts while idle bursts are on.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      out_if.ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left    <= $urandom_range(0, 7);
      out_if.ready  <= 1'b0;
    end else begin
      out_if.ready  <= 1'b1;
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("record_image_checker_crc32_core regression: fail");
      $finish;
    end
  end

  // Sends one byte beat, with an optional idle burst ahead of it.
  task automatic send_beat(input logic [7:0] b, input logic first);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.rec_byte  <= b;
    in_if.rec_first <= first;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_image(input image_t img, input int count, input logic first);
    for (int i = 0; i < count; i++) send_beat(img[i], (i == 0) ? first : 1'b0);
  endtask

  // Holds the sender until every pending record has come out; ends on a negedge.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(negedge clk_i); while (decoded_q.size() != 0);
  endtask

  // Plays one stream case; random bodies where no fill is given.
  task automatic play_row(input row_kind_e kind, input logic [7:0] fill, input bit use_fill);
    image_t img;
    logic   first;
    int     n;
    img   = build_image(use_fill, fill);
    first = need_first ? 1'b1 : 1'($urandom_range(0, 1));
    need_first = 1'b0;
    case (kind)
      RowGood: begin
        send_image(img, RecordLen, first);
      end
      RowBadFirst: begin
        img[0] = use_fill ? 8'h00 : img[0] ^ 8'(1 << $urandom_range(0, 7));
        send_image(seal_image(img), RecordLen, first);
      end
      RowBadSecond: begin
        img[1] = use_fill ? 8'hFF : img[1] ^ 8'(1 << $urandom_range(0, 7));
        send_image(seal_image(img), RecordLen, first);
      end
      RowBadCheck: begin
        n = $urandom_range(0, RecordLen - 1);
        img[n] = img[n] ^ 8'(1 << $urandom_range(0, 7));
        send_image(img, RecordLen, first);
      end
      RowRestart: begin
        // A partial record, then a full one that restarts framing.
        n = use_fill ? 20 : $urandom_range(1, RecordLen - 1);
        send_image(img, n, first);
        send_image(build_image(1'b0, 8'h00), RecordLen, 1'b1);
      end
      RowChained: begin
        // Position has wrapped, so byte 0 needs no start flag.
        send_image(img, RecordLen, 1'b0);
      end
      RowNoise: begin
        n = $urandom_range(1, 40);
        for (int i = 0; i < n; i++) begin
          send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 7) == 0));
        end
        need_first = 1'b1;
      end
      default: begin
        send_image(img, RecordLen, first);
      end
    endcase
  endtask

  // Stimulus.
  initial begin
    int        dir_bytes;
    int        dice;
    int        records;
    row_kind_e kind;

    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.rec_byte  = '0;
    in_if.rec_first = 1'b0;
    out_if.ready    = 1'b0;
    records         = 0;

    // Layout cases; expected results typed in where they are obvious.
    dir_rows[0] = '{RowGood,      8'h00, 1'b1, 1'b1, '{record_ok: 1'b1, default: '0}};
    dir_rows[1] = '{RowGood,      8'hFF, 1'b1, 1'b1, '{record_ok: 1'b1, default: '1}};
    dir_rows[2] = '{RowBadFirst,  8'h00, 1'b1, 1'b1, '0};
    dir_rows[3] = '{RowBadSecond, 8'hFF, 1'b1, 1'b1, '0};
    dir_rows[4] = '{RowBadCheck,  8'h5A, 1'b1, 1'b1, '0};
    dir_rows[5] = '{RowRestart,   8'h00, 1'b1, 1'b0, '0};
    dir_rows[6] = '{RowChained,   8'h00, 1'b0, 1'b0, '0};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, one row at a time with the results drained in between.
    idle_on = 1'b1;
    foreach (dir_rows[r]) begin
      play_row(dir_rows[r].kind, dir_rows[r].fill, dir_rows[r].use_fill);
      drain_results();
      if (dir_rows[r].typed) check_record(dir_rows[r].want, last_beat);
      @(posedge clk_i);
    end
    dir_bytes = bytes_sent;

    // Random part: mostly well-formed records, some corrupted or noise.
    while (bytes_sent - dir_bytes < RandomBytes) begin
      idle_on = ($urandom_range(0, 3) != 0) && (bytes_sent - dir_bytes < RandomBytes * 4 / 5);
      dice = $urandom_range(0, 99);
      if (dice < 55)      kind = RowGood;
      else if (dice < 62) kind = RowChained;
      else if (dice < 68) kind = RowBadFirst;
      else if (dice < 74) kind = RowBadSecond;
      else if (dice < 84) kind = RowBadCheck;
      else if (dice < 94) kind = RowRestart;
      else                kind = RowNoise;
      // Chaining only makes sense on a record boundary.
      if (kind == RowChained && need_first) kind = RowGood;
      play_row(kind, 8'h00, 1'b0);
      records++;
      if (records == 10) begin
        drain_results();
        @(posedge clk_i);
      end
    end

    // Wind down.
    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (decoded_q.size() != 0) begin
      $error("%0d record results never came out", decoded_q.size());
      mismatches++;
    end

    $display("Sent %0d bytes; checked %0d record results, %0d accepted and %0d rejected.",
             bytes_sent, results_got, ok_got, results_got - ok_got);
    $display("Cases: good, chained, bad magic, bad CRC, restart mid-record and noise.");
    if (mismatches == 0) begin
      $display("record_image_checker_crc32_core regression: pass");
    end else begin
      $display("record_image_checker_crc32_core regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
design/rici_pkg.sv
design/rici_in_if.sv
design/rici_out_if.sv
design/rici_frame.sv
design/rici_out_reg.sv
design/record_image_checker_crc32_core.sv
dv/tb_top.sv
